### rtl/mrf_pkg.sv
// shared types, constants and the crc byte step of the modbus read request framer
package mrf_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int IDX_W  = 4;

    localparam logic [WORD_W-1:0] CRC_INIT     = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY     = 16'hA001;
    localparam logic [BYTE_W-1:0] PROTO_ID_B   = 8'h00;
    localparam logic [BYTE_W-1:0] TCP_LEN_HI   = 8'h00;
    localparam logic [BYTE_W-1:0] TCP_LEN_LO   = 8'h06;
    localparam logic [IDX_W-1:0]  HDR_LEN      = 4'd6;
    localparam logic [IDX_W-1:0]  RTU_LAST_IDX = 4'd7;
    localparam logic [IDX_W-1:0]  TCP_LAST_IDX = 4'd11;

    typedef struct packed {
        logic [BYTE_W-1:0] device_address;
        logic [BYTE_W-1:0] function_code;
        logic [WORD_W-1:0] start_address;
        logic [WORD_W-1:0] item_count;
    } req_t;

    // one byte of crc-16/modbus, bit by bit, lsb first
    function automatic logic [WORD_W-1:0] crc_step(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [WORD_W-1:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/mrf_req_if.sv
// request channel: one read request per beat
interface mrf_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  device_address;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] item_count;

    modport source (output valid, device_address, function_code, start_address, item_count,
                    input ready);
    modport sink   (input valid, device_address, function_code, start_address, item_count,
                    output ready);
endinterface

### rtl/mrf_byte_if.sv
// frame byte channel: one frame byte per beat, last byte marked
interface mrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

### rtl/mrf_serializer.sv
// holds one request, walks its frame bytes into the output register, folds in the crc in rtu mode
module mrf_serializer
    import mrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tcp_mode,
    input  logic [WORD_W-1:0] tid,
    mrf_req_if.sink           req,
    mrf_byte_if.source        frame
);

    logic              busy_reg,      busy_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  idx_reg,       idx_next;
    logic              tcp_reg;
    logic [WORD_W-1:0] tid_reg;
    logic [WORD_W-1:0] crc_reg;
    req_t              req_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              load;
    logic              is_last;
    logic              accept;
    logic [BYTE_W-1:0] cur_byte;

    assign load    = busy_reg && (!out_valid_reg || frame.ready);
    assign is_last = tcp_reg ? (idx_reg == TCP_LAST_IDX) : (idx_reg == RTU_LAST_IDX);
    // a new request may enter while the last byte of the previous one moves out
    assign req.ready = !busy_reg || (load && is_last);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        cur_byte = 8'h00;
        if (tcp_reg)
        begin
            case (idx_reg)
                4'd0:    cur_byte = tid_reg[15:8];
                4'd1:    cur_byte = tid_reg[7:0];
                4'd2:    cur_byte = PROTO_ID_B;
                4'd3:    cur_byte = PROTO_ID_B;
                4'd4:    cur_byte = TCP_LEN_HI;
                4'd5:    cur_byte = TCP_LEN_LO;
                4'd6:    cur_byte = req_reg.device_address;
                4'd7:    cur_byte = req_reg.function_code;
                4'd8:    cur_byte = req_reg.start_address[15:8];
                4'd9:    cur_byte = req_reg.start_address[7:0];
                4'd10:   cur_byte = req_reg.item_count[15:8];
                4'd11:   cur_byte = req_reg.item_count[7:0];
                default: cur_byte = 8'h00;
            endcase
        end
        else
        begin
            case (idx_reg)
                4'd0:    cur_byte = req_reg.device_address;
                4'd1:    cur_byte = req_reg.function_code;
                4'd2:    cur_byte = req_reg.start_address[15:8];
                4'd3:    cur_byte = req_reg.start_address[7:0];
                4'd4:    cur_byte = req_reg.item_count[15:8];
                4'd5:    cur_byte = req_reg.item_count[7:0];
                // crc goes low byte first
                4'd6:    cur_byte = crc_reg[7:0];
                4'd7:    cur_byte = crc_reg[15:8];
                default: cur_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 4'd1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
            if (!tcp_reg && (idx_reg < HDR_LEN))
            begin
                crc_reg <= crc_step(crc_reg, cur_byte);
            end
        end
        if (accept)
        begin
            req_reg.device_address <= req.device_address;
            req_reg.function_code  <= req.function_code;
            req_reg.start_address  <= req.start_address;
            req_reg.item_count     <= req.item_count;
            tcp_reg                <= tcp_mode;
            tid_reg                <= tid;
            crc_reg                <= CRC_INIT;
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.last_byte  = out_last_reg;

endmodule

### rtl/modbus_read_request_framer.sv
// modbus read request framer: one request in, an rtu or tcp frame out one byte per beat
// the request is registered first, then its first frame byte moves into the output register
// frames are 8 bytes in rtu mode, 12 in tcp mode, sent one byte per cycle while frame ready
// holds, through the single output register; the next request is taken with the last byte
// reset: rtu mode, transaction counter zero, no bytes pending
module modbus_read_request_framer
    import mrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    mrf_req_if.sink    req,
    mrf_byte_if.source frame
);

    logic              tcp_mode_reg;
    logic [WORD_W-1:0] tid_reg, tid_next;
    logic [WORD_W-1:0] tid_inc;

    // counter advances before use, wraps naturally at 16 bits
    assign tid_inc  = tid_reg + 16'd1;
    assign tid_next = (req.valid && req.ready && tcp_mode_reg) ? tid_inc : tid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcp_mode_reg <= 1'b0;
            tid_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tcp_mode_reg <= cfg_wdata;
            end
            tid_reg <= tid_next;
        end
    end

    mrf_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .tcp_mode (tcp_mode_reg),
        .tid      (tid_inc),
        .req      (req),
        .frame    (frame)
    );

endmodule
